@@ sv/bfa_pkg.sv @@
// Shared constants, types and helper functions of the bitmap frame allocator.
package bfa_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned MAP_WORDS  = 128;
  localparam int unsigned MAP_FRAMES = MAP_WORDS * WORD_BITS;
  localparam int unsigned MAP_AW     = $clog2(MAP_WORDS);
  localparam int unsigned WIDX_W     = MAP_AW + 1;
  localparam int unsigned OFF_W      = $clog2(WORD_BITS);
  localparam int unsigned CNT_W      = 13;

  localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  typedef struct packed {
    logic                 en;
    logic [MAP_AW-1:0]    addr;
    logic [WORD_BITS-1:0] data;
  } map_wr_t;

  function automatic logic [5:0] popcount32(input logic [WORD_BITS-1:0] v);
    logic [1:0] s2 [16];
    logic [2:0] s4 [8];
    logic [3:0] s8 [4];
    logic [4:0] s16 [2];
    for (int i = 0; i < 16; i++) begin
      s2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s4[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s8[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s16[i] = {1'b0, s8[2*i]} + {1'b0, s8[2*i+1]};
    end
    return {1'b0, s16[0]} + {1'b0, s16[1]};
  endfunction

  function automatic logic [WIDX_W-1:0] frames_to_words(input logic [CNT_W-1:0] v);
    logic [WIDX_W-1:0] w;
    if (v >= CNT_W'(MAP_FRAMES)) begin
      w = WIDX_W'(MAP_WORDS);
    end else begin
      w = {1'b0, v[OFF_W +: MAP_AW]};
    end
    return w;
  endfunction

endpackage

@@ sv/bfa_map.sv @@
// Frame bitmap memory with per-word valid bits; invalid words read as zero.
module bfa_map (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clear_i,
  input  logic [bfa_pkg::MAP_AW-1:0]      rd_addr_i,
  output logic [bfa_pkg::WORD_BITS-1:0]   rd_data_o,
  input  bfa_pkg::map_wr_t                wr_i
);

  logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::MAP_WORDS];
  logic [bfa_pkg::MAP_WORDS-1:0] valid_q;
  logic [bfa_pkg::WORD_BITS-1:0] rd_data_q;
  logic                          rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

@@ sv/bfa_run_finder.sv @@
// Finds the lowest offset in one bitmap word where a run of free frames fits.
module bfa_run_finder (
  input  logic [bfa_pkg::WORD_BITS-1:0] word_i,
  input  logic [5:0]                    count_i,
  output logic                          found_o,
  output logic [bfa_pkg::OFF_W-1:0]     offset_o,
  output logic [bfa_pkg::WORD_BITS-1:0] mask_o
);

  logic [bfa_pkg::WORD_BITS-1:0] run;
  logic [bfa_pkg::WORD_BITS-1:0] cand;

  always_comb begin
    if (count_i >= 6'd32) begin
      run = bfa_pkg::FULL_WORD;
    end else begin
      run = (32'd1 << count_i) - 32'd1;
    end
    for (int j = 0; j < bfa_pkg::WORD_BITS; j++) begin
      cand[j] = ((word_i & (run << j)) == '0) &&
                ((7'(j) + {1'b0, count_i}) <= 7'd32);
    end
    offset_o = '0;
    for (int j = bfa_pkg::WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        offset_o = bfa_pkg::OFF_W'(j);
      end
    end
    found_o = |cand;
    mask_o  = run << offset_o;
  end

endmodule

@@ sv/bitmap_frame_allocator.sv @@
// Top level of the bitmap frame allocator: command sequencer, map and run finder.
// A rejected or unknown command is answered from idle without raising busy; alloc scans
// words from the hint word up, free clears each word that its frames touch, and init
// writes the reserved frames as used, word by word.
// One item at a time; busy stays high while the map is scanned one word per cycle,
// and the next item is accepted in the cycle of the done strobe; results never stall.
// Reset empties the map through per-word valid bits at once; no clearing pass is run.
module bitmap_frame_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [bfa_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       cmd_i,
  input  logic [5:0]                       frame_count_i,
  input  logic [11:0]                      base_frame_i,
  output logic                             done_o,
  output logic [11:0]                      frame_index_o,
  output logic                             success_o,
  output logic [bfa_pkg::CNT_W-1:0]        frames_in_use_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INIT  = 2'd1;
  localparam logic [1:0] ST_ALLOC = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  localparam int unsigned MW = 3 * bfa_pkg::WORD_BITS;
  localparam int unsigned WB = bfa_pkg::WORD_BITS;
  localparam int unsigned XW = bfa_pkg::WIDX_W;

  logic [1:0]                  state_q, state_d;
  logic [XW-1:0]               w_q, w_d;
  logic [XW-1:0]               hint_q, hint_d;
  logic [bfa_pkg::CNT_W-1:0]   used_q, used_d;
  logic [bfa_pkg::CNT_W-1:0]   total_q, reserved_q;
  logic                        done_q, done_d;
  logic                        success_q, success_d;
  logic [11:0]                 index_q, index_d;
  logic [5:0]                  cnt_q, cnt_d;
  logic [MW-1:0]               mask_q, mask_d;
  logic [XW-1:0]               resw_q, resw_d;
  logic [bfa_pkg::OFF_W-1:0]   rem_q, rem_d;

  logic                        map_clear;
  logic [bfa_pkg::MAP_AW-1:0]  rd_addr;
  logic [WB-1:0]               rd_data;
  bfa_pkg::map_wr_t            map_wr;

  logic                        fit_found;
  logic [bfa_pkg::OFF_W-1:0]   fit_off;
  logic [WB-1:0]               fit_mask;

  logic [XW-1:0]               limit;
  logic [XW-1:0]               w_next;
  logic [bfa_pkg::CNT_W-1:0]   res_cap;
  logic [MW-1:0]               free_mask;
  logic [XW-1:0]               base_word;
  logic [WB-1:0]               cleared;

  bfa_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (map_clear),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (map_wr)
  );

  bfa_run_finder u_finder (
    .word_i   (rd_data),
    .count_i  (cnt_q),
    .found_o  (fit_found),
    .offset_o (fit_off),
    .mask_o   (fit_mask)
  );

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign success_o       = success_q;
  assign frame_index_o   = index_q;
  assign frames_in_use_o = used_q;

  assign limit     = bfa_pkg::frames_to_words(total_q);
  assign res_cap   = (reserved_q > bfa_pkg::CNT_W'(bfa_pkg::MAP_FRAMES)) ?
                     bfa_pkg::CNT_W'(bfa_pkg::MAP_FRAMES) : reserved_q;
  assign w_next    = w_q + XW'(1);
  assign base_word = {1'b0, base_frame_i[11:bfa_pkg::OFF_W]};
  assign free_mask = MW'((64'd1 << frame_count_i) - 64'd1) << base_frame_i[bfa_pkg::OFF_W-1:0];
  assign cleared   = rd_data & mask_q[WB-1:0];

  always_comb begin
    state_d   = state_q;
    w_d       = w_q;
    hint_d    = hint_q;
    used_d    = used_q;
    done_d    = 1'b0;
    success_d = success_q;
    index_d   = index_q;
    cnt_d     = cnt_q;
    mask_d    = mask_q;
    resw_d    = resw_q;
    rem_d     = rem_q;
    map_clear = 1'b0;
    rd_addr   = w_q[bfa_pkg::MAP_AW-1:0];
    map_wr    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_i)
            bfa_pkg::CMD_INIT: begin
              map_clear = 1'b1;
              resw_d    = bfa_pkg::frames_to_words(res_cap);
              rem_d     = res_cap[bfa_pkg::OFF_W-1:0];
              used_d    = res_cap;
              hint_d    = bfa_pkg::frames_to_words(res_cap);
              w_d       = '0;
              state_d   = ST_INIT;
            end
            bfa_pkg::CMD_ALLOC: begin
              cnt_d   = frame_count_i;
              w_d     = hint_q;
              rd_addr = hint_q[bfa_pkg::MAP_AW-1:0];
              if (frame_count_i == 6'd0 || frame_count_i > 6'd32 || hint_q >= limit) begin
                done_d    = 1'b1;
                success_d = 1'b0;
                index_d   = '0;
              end else begin
                state_d = ST_ALLOC;
              end
            end
            bfa_pkg::CMD_FREE: begin
              mask_d  = free_mask;
              w_d     = base_word;
              rd_addr = base_word[bfa_pkg::MAP_AW-1:0];
              if (base_word < hint_q) begin
                hint_d = base_word;
              end
              if (free_mask == '0) begin
                done_d    = 1'b1;
                success_d = 1'b1;
                index_d   = '0;
              end else begin
                state_d = ST_FREE;
              end
            end
            default: begin
              done_d    = 1'b1;
              success_d = 1'b0;
              index_d   = '0;
            end
          endcase
        end
      end

      ST_INIT: begin
        if (w_q == resw_q) begin
          if (!w_q[XW-1]) begin
            map_wr.en   = 1'b1;
            map_wr.addr = w_q[bfa_pkg::MAP_AW-1:0];
            map_wr.data = (32'd1 << rem_q) - 32'd1;
          end
          done_d    = 1'b1;
          success_d = 1'b1;
          index_d   = '0;
          state_d   = ST_IDLE;
        end else begin
          map_wr.en   = 1'b1;
          map_wr.addr = w_q[bfa_pkg::MAP_AW-1:0];
          map_wr.data = bfa_pkg::FULL_WORD;
          w_d         = w_next;
        end
      end

      ST_ALLOC: begin
        if (fit_found) begin
          map_wr.en   = 1'b1;
          map_wr.addr = w_q[bfa_pkg::MAP_AW-1:0];
          map_wr.data = rd_data | fit_mask;
          used_d      = used_q + bfa_pkg::CNT_W'(cnt_q);
          done_d      = 1'b1;
          success_d   = 1'b1;
          index_d     = {w_q[bfa_pkg::MAP_AW-1:0], fit_off};
          state_d     = ST_IDLE;
        end else begin
          if (rd_data == bfa_pkg::FULL_WORD && w_q == hint_q) begin
            hint_d = hint_q + XW'(1);
          end
          if (w_next >= limit) begin
            done_d    = 1'b1;
            success_d = 1'b0;
            index_d   = '0;
            state_d   = ST_IDLE;
          end else begin
            rd_addr = w_next[bfa_pkg::MAP_AW-1:0];
            w_d     = w_next;
          end
        end
      end

      ST_FREE: begin
        map_wr.en   = 1'b1;
        map_wr.addr = w_q[bfa_pkg::MAP_AW-1:0];
        map_wr.data = rd_data & ~mask_q[WB-1:0];
        used_d      = used_q - bfa_pkg::CNT_W'(bfa_pkg::popcount32(cleared));
        mask_d      = mask_q >> WB;
        if (mask_d == '0 || w_next[XW-1]) begin
          done_d    = 1'b1;
          success_d = 1'b1;
          index_d   = '0;
          state_d   = ST_IDLE;
        end else begin
          rd_addr = w_next[bfa_pkg::MAP_AW-1:0];
          w_d     = w_next;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      hint_q     <= '0;
      used_q     <= '0;
      done_q     <= 1'b0;
      total_q    <= bfa_pkg::CNT_W'(bfa_pkg::MAP_FRAMES);
      reserved_q <= '0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      used_q  <= used_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bfa_pkg::REG_TOTAL:    total_q    <= cfg_wdata_i;
          bfa_pkg::REG_RESERVED: reserved_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    success_q <= success_d;
    index_q   <= index_d;
    cnt_q     <= cnt_d;
    mask_q    <= mask_d;
    resw_q    <= resw_d;
    rem_q     <= rem_d;
  end

endmodule

@@ sv/bfa_checker.sv @@
// Port-level checks of the bitmap frame allocator and their binding.
module bfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [11:0] frame_index_o,
  input logic        success_o,
  input logic [12:0] frames_in_use_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !success_o) |-> (frame_index_o == 12'd0))
    else $error("failed command reports a nonzero frame");

  a_busy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  a_accept_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted item neither started nor answered");

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (frames_in_use_o <= 13'd4096))
    else $error("used frame count beyond the map");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .frame_index_o   (frame_index_o),
  .success_o       (success_o),
  .frames_in_use_o (frames_in_use_o)
);
